[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define ASSERT_ON(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_ON(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

[hw/rtl/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// Types and constants shared by the substring search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

   localparam int BYTE_W        = 8;
   localparam int LEN_W         = 5;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 2;
   localparam int LIMIT_W       = 16;
   localparam int MATCH_START_W = 16;

   typedef logic [BYTE_W-1:0]        byte_type;
   typedef logic [LEN_W-1:0]         len_type;
   typedef logic [CSR_INDEX_W-1:0]   csr_index_type;
   typedef logic [CSR_DATA_W-1:0]    csr_data_type;
   typedef logic [LIMIT_W-1:0]       limit_type;
   typedef logic [MATCH_START_W-1:0] match_start_type;

   localparam byte_type TERMINATOR = 8'h00;

   // register indexes
   localparam csr_index_type CSR_NEEDLE_LENGTH = 2'd0;
   localparam csr_index_type CSR_NEEDLE_LOW    = 2'd1;
   localparam csr_index_type CSR_NEEDLE_HIGH   = 2'd2;
   localparam csr_index_type CSR_SEARCH_LIMIT  = 2'd3;

endpackage

`default_nettype wire

[hw/rtl/bss_req_if.sv]
// ----------------------------------------------------------------------------
// bss_req_if
// Haystack byte channel: valid/ready handshake with byte and restart flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bss_req_if;

   logic               valid;
   logic               ready;
   bss_pkg::byte_type  haystack_byte;
   logic               first_byte;

   modport source (output valid, output haystack_byte, output first_byte, input ready);
   modport sink   (input valid, input haystack_byte, input first_byte, output ready);

endinterface

`default_nettype wire

[hw/rtl/bss_rsp_if.sv]
// ----------------------------------------------------------------------------
// bss_rsp_if
// Search status channel: valid/ready handshake with found, start and done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bss_rsp_if;

   logic                     valid;
   logic                     ready;
   logic                     found;
   bss_pkg::match_start_type match_start;
   logic                     finished;

   modport source (output valid, output found, output match_start, output finished,
                   input ready);
   modport sink   (input valid, input found, input match_start, input finished,
                   output ready);

endinterface

`default_nettype wire

[hw/rtl/bss_window_match.sv]
// ----------------------------------------------------------------------------
// bss_window_match
// Parallel compare of the byte window against the first n needle bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bss_window_match #(
   parameter int NEEDLE_MAX = 16
) (
   input  wire logic [NEEDLE_MAX-1:0][bss_pkg::BYTE_W-1:0] win,
   input  wire logic [NEEDLE_MAX-1:0][bss_pkg::BYTE_W-1:0] needle,
   input  wire bss_pkg::len_type                           needle_len,
   output logic                                            hit
);

   localparam int IDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

   // window entry 0 is the newest byte, so needle byte j sits at n-1-j
   always_comb begin
      logic                  all_eq;
      bss_pkg::len_type      pos;
      logic [IDX_W-1:0]      idx;
      all_eq = 1'b1;
      for (int j = 0; j < NEEDLE_MAX; j++) begin
         pos = needle_len - bss_pkg::len_type'(j + 1);
         idx = pos[IDX_W-1:0];
         if (bss_pkg::len_type'(j) < needle_len) begin
            if (win[idx] != needle[j]) begin
               all_eq = 1'b0;
            end
         end
      end
      hit = all_eq;
   end

endmodule

`default_nettype wire

[hw/rtl/bounded_substring_search.sv]
// ----------------------------------------------------------------------------
// bounded_substring_search
// Streaming bounded substring search over a haystack byte stream.
// ----------------------------------------------------------------------------
// The block takes one haystack byte per cycle and returns one status word per
// byte, valid in the cycle after the byte is accepted; the rate is set by the
// same-cycle update of the byte window, the parallel needle compare and the
// position counter, and a result register sits between the two channels, so a
// new byte is taken in the same cycle the previous word leaves and the input
// stalls only while a word waits on a low rsp ready. The status word reports whether
// the needle (up to NEEDLE_MAX bytes, needle_length of them in use) has been
// found wholly inside the first search_limit bytes and before any zero byte,
// the offset of its first byte, and whether the search has ended (hit, zero
// byte, or limit). A byte flagged first_byte restarts the search at offset 0.
// An empty needle matches at offset 0. Overlapping starts are all tested.
// Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bounded_substring_search #(
   parameter int NEEDLE_MAX    = 16,
   parameter int POSITION_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   bss_req_if.sink                      req,
   bss_rsp_if.source                    rsp,
   input  wire logic                    csr_wr_en,
   input  wire bss_pkg::csr_index_type  csr_index,
   input  wire bss_pkg::csr_data_type   csr_wdata
);

   localparam int CMP_W = (POSITION_BITS + 1 > bss_pkg::LIMIT_W + 1) ?
                          POSITION_BITS + 1 : bss_pkg::LIMIT_W + 1;

   // configuration
   bss_pkg::len_type      needle_length_ff;
   bss_pkg::csr_data_type needle_low_ff;
   bss_pkg::csr_data_type needle_high_ff;
   bss_pkg::limit_type    search_limit_ff;

   // search state
   logic [NEEDLE_MAX-1:0][bss_pkg::BYTE_W-1:0] win_ff, win_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     hit_ff, hit_in;
   logic [POSITION_BITS-1:0] off_ff, off_in;
   logic                     over_ff, over_in;

   // result register
   logic                     rsp_valid_ff;
   logic                     found_ff;
   bss_pkg::match_start_type match_start_ff;
   logic                     finished_ff;

   logic [NEEDLE_MAX-1:0][bss_pkg::BYTE_W-1:0] needle;
   logic [NEEDLE_MAX-1:0][bss_pkg::BYTE_W-1:0] win_shift;
   bss_pkg::len_type         needle_len;
   logic                     win_hit;
   logic                     accept;
   logic                     req_ready;

   assign req_ready = !rsp_valid_ff || rsp.ready;
   assign req.ready = req_ready;
   assign accept    = req.valid && req_ready;

   // clamp overlong lengths
   assign needle_len = (needle_length_ff > bss_pkg::len_type'(NEEDLE_MAX)) ?
                       bss_pkg::len_type'(NEEDLE_MAX) : needle_length_ff;

   always_comb begin
      logic [2*bss_pkg::CSR_DATA_W-1:0] needle_all;
      needle_all = {needle_high_ff, needle_low_ff};
      for (int k = 0; k < NEEDLE_MAX; k++) begin
         needle[k] = needle_all[bss_pkg::BYTE_W*k +: bss_pkg::BYTE_W];
      end
   end

   // entries past the count are never compared, so the window needs no clear
   always_comb begin
      win_shift[0] = req.haystack_byte;
      for (int i = 1; i < NEEDLE_MAX; i++) begin
         win_shift[i] = win_ff[i-1];
      end
   end

   bss_window_match #(
      .NEEDLE_MAX (NEEDLE_MAX)
   ) u_match (
      .win        (win_shift),
      .needle     (needle),
      .needle_len (needle_len),
      .hit        (win_hit)
   );

   always_comb begin
      logic [POSITION_BITS-1:0] pos_cur;
      logic                     hit_cur;
      logic [POSITION_BITS-1:0] off_cur;
      logic                     over_cur;
      logic [POSITION_BITS:0]   count;
      logic [CMP_W-1:0]         count_ext;
      logic [CMP_W-1:0]         len_ext;
      logic [CMP_W-1:0]         limit_ext;
      logic [CMP_W-1:0]         pmax_ext;
      logic [CMP_W-1:0]         start_ext;

      // restart: start from a cleared search
      pos_cur  = req.first_byte ? '0   : pos_ff;
      hit_cur  = req.first_byte ? 1'b0 : hit_ff;
      off_cur  = req.first_byte ? '0   : off_ff;
      over_cur = req.first_byte ? 1'b0 : over_ff;

      count     = {1'b0, pos_cur} + (POSITION_BITS+1)'(1);
      count_ext = CMP_W'(count);
      len_ext   = CMP_W'(needle_len);
      limit_ext = CMP_W'(search_limit_ff);
      pmax_ext  = CMP_W'({POSITION_BITS{1'b1}});
      start_ext = count_ext - len_ext;

      win_in  = win_ff;
      pos_in  = pos_cur;
      hit_in  = hit_cur;
      off_in  = off_cur;
      over_in = over_cur;

      if (!over_cur) begin
         priority if (needle_len == '0) begin
            hit_in  = 1'b1;
            off_in  = '0;
            over_in = 1'b1;
         end else if (req.haystack_byte == bss_pkg::TERMINATOR) begin
            over_in = 1'b1;
         end else begin
            win_in = win_shift;
            pos_in = count[POSITION_BITS-1:0];
            if (count_ext >= len_ext && count_ext <= limit_ext && win_hit) begin
               hit_in  = 1'b1;
               off_in  = start_ext[POSITION_BITS-1:0];
               over_in = 1'b1;
            end
            if (count_ext >= limit_ext || count_ext >= pmax_ext) begin
               over_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_length_ff <= '0;
         needle_low_ff    <= '0;
         needle_high_ff   <= '0;
         search_limit_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bss_pkg::CSR_NEEDLE_LENGTH: begin
               needle_length_ff <= csr_wdata[bss_pkg::LEN_W-1:0];
            end
            bss_pkg::CSR_NEEDLE_LOW: begin
               needle_low_ff <= csr_wdata;
            end
            bss_pkg::CSR_NEEDLE_HIGH: begin
               needle_high_ff <= csr_wdata;
            end
            bss_pkg::CSR_SEARCH_LIMIT: begin
               search_limit_ff <= csr_wdata[bss_pkg::LIMIT_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         hit_ff  <= 1'b0;
         off_ff  <= '0;
         over_ff <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         hit_ff  <= hit_in;
         off_ff  <= off_in;
         over_ff <= over_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // load the word from the updated state
   always_ff @(posedge clock) begin
      logic [CMP_W-1:0] off_ext;
      off_ext = CMP_W'(off_in);
      if (accept) begin
         found_ff       <= hit_in;
         match_start_ff <= hit_in ? off_ext[bss_pkg::MATCH_START_W-1:0] : '0;
         finished_ff    <= over_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.found       = found_ff;
   assign rsp.match_start = match_start_ff;
   assign rsp.finished    = finished_ff;

   `ASSERT_NEVER(a_hit_implies_over, clock, reset, hit_ff && !over_ff)
   `ASSERT_ON(a_found_implies_finished, clock, reset,
              rsp_valid_ff && found_ff |-> finished_ff)
   `ASSERT_ON(a_empty_needle_hits_at_zero, clock, reset,
              accept && req.first_byte && needle_len == '0 |=>
              found_ff && match_start_ff == '0 && finished_ff)
   `ASSERT_ON(a_terminator_ends_without_hit, clock, reset,
              accept && !req.first_byte && !over_ff && needle_len != '0 &&
              req.haystack_byte == bss_pkg::TERMINATOR |=> over_ff && !hit_ff)
   `ASSERT_ON(a_no_progress_after_end, clock, reset,
              accept && !req.first_byte && over_ff |=>
              $stable(pos_ff) && $stable(off_ff) && $stable(hit_ff))

endmodule

`default_nettype wire
